[rtl/mer_pkg.sv]
// Shared types and constants for the midpoint ellipse rasterizer.
`timescale 1ns / 1ps

package mer_pkg;

	localparam int QUADS      = 4;
	localparam int COLOR_BITS = 24;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_STEP  = 1'b1;

	typedef enum logic [3:0] {
		ST_WAIT,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_MUL4,
		ST_MUL5,
		ST_ADV1,
		ST_ADV2,
		ST_ADV3,
		ST_EMIT
	} mer_state_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ONE,
		PH_TWO
	} mer_phase_t;

	typedef enum logic [1:0] {
		EK_START,
		EK_IDLE,
		EK_POINT
	} mer_kind_t;

	typedef enum logic [2:0] {
		MS_RXSQ,
		MS_RYSQ,
		MS_X1,
		MS_Y2,
		MS_SX1,
		MS_SY2
	} mer_mul_t;

	typedef struct packed {
		logic      load;
		logic      snap;
		logic      mul_en;
		mer_mul_t  mul_sel;
		logic      r1_init;
		logic      adv1;
		logic      adv2;
		logic      adv3;
		logic      emit;
		mer_kind_t kind;
	} mer_ctrl_t;

	typedef struct packed {
		logic idle;
		logic last;
		logic out_free;
	} mer_stat_t;

endpackage

[rtl/mer_req_if.sv]
// Request channel: start or step words into the rasterizer.
`timescale 1ns / 1ps

interface mer_req_if import mer_pkg::*; #(
	parameter int RADIUS_BITS = 10,
	parameter int COORD_BITS  = 12
);
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic signed [COORD_BITS-1:0]  center_x;
	logic signed [COORD_BITS-1:0]  center_y;
	logic [RADIUS_BITS-1:0]        radius_x;
	logic [RADIUS_BITS-1:0]        radius_y;
	logic [QUADS-1:0]              quadrants;
	logic                          fill_mode;
	logic [COLOR_BITS-1:0]         line_color;
	logic [COLOR_BITS-1:0]         fill_color;

	modport source (
		output valid, req_type, center_x, center_y, radius_x, radius_y,
		       quadrants, fill_mode, line_color, fill_color,
		input  ready
	);

	modport sink (
		input  valid, req_type, center_x, center_y, radius_x, radius_y,
		       quadrants, fill_mode, line_color, fill_color,
		output ready
	);
endinterface

[rtl/mer_res_if.sv]
// Result channel: pixel and span words out of the rasterizer.
`timescale 1ns / 1ps

interface mer_res_if import mer_pkg::*; #(
	parameter int RADIUS_BITS = 10,
	parameter int COORD_BITS  = 12
);
	logic                       valid;
	logic                       ready;
	logic signed [COORD_BITS:0] pixel_x;
	logic signed [COORD_BITS:0] pixel_y;
	logic [RADIUS_BITS:0]       span_length;
	logic [COLOR_BITS-1:0]      out_color;
	logic                       has_pixel;
	logic                       is_last;
	logic                       done_res;

	modport source (
		output valid, pixel_x, pixel_y, span_length, out_color, has_pixel,
		       is_last, done_res,
		input  ready
	);

	modport sink (
		input  valid, pixel_x, pixel_y, span_length, out_color, has_pixel,
		       is_last, done_res,
		output ready
	);
endinterface

[rtl/mer_ctrl.sv]
// Sequencer for the rasterizer: start multiplies, walk advance and word emission.
`timescale 1ns / 1ps

module mer_ctrl import mer_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_type,
	output logic      req_ready,
	input  mer_stat_t stat,
	output mer_ctrl_t ctrl
);

	mer_state_t state_q, state_d;
	mer_kind_t  kind_q, kind_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WAIT;
			kind_q  <= EK_START;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		unique case (state_q)
			ST_WAIT: begin
				if (req_valid) begin
					if (req_type == REQ_START) begin
						state_d = ST_MUL0;
						kind_d  = EK_START;
					end else if (stat.idle) begin
						state_d = ST_EMIT;
						kind_d  = EK_IDLE;
					end else begin
						state_d = ST_ADV1;
						kind_d  = EK_POINT;
					end
				end
			end
			ST_MUL0: state_d = ST_MUL1;
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_MUL3;
			ST_MUL3: state_d = ST_MUL4;
			ST_MUL4: state_d = ST_MUL5;
			ST_MUL5: state_d = ST_EMIT;
			ST_ADV1: state_d = ST_ADV2;
			ST_ADV2: state_d = ST_ADV3;
			ST_ADV3: state_d = ST_EMIT;
			ST_EMIT: begin
				// stay until the output is free and, for a step, the last quadrant word has been loaded
				if (stat.out_free && (kind_q != EK_POINT || stat.last)) begin
					state_d = ST_WAIT;
				end
			end
			default: state_d = ST_WAIT;
		endcase
	end

	always_comb begin
		ctrl      = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_WAIT: begin
				req_ready = 1'b1;
				ctrl.load = req_valid && (req_type == REQ_START);
				ctrl.snap = req_valid && (req_type == REQ_STEP) && !stat.idle;
			end
			ST_MUL0: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MS_RXSQ;
			end
			ST_MUL1: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MS_RYSQ;
			end
			ST_MUL2: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MS_X1;
			end
			ST_MUL3: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MS_Y2;
			end
			ST_MUL4: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MS_SX1;
			end
			ST_MUL5: begin
				// region one terms are ready; the last product is for region two
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MS_SY2;
				ctrl.r1_init = 1'b1;
			end
			ST_ADV1: ctrl.adv1 = 1'b1;
			ST_ADV2: ctrl.adv2 = 1'b1;
			ST_ADV3: ctrl.adv3 = 1'b1;
			ST_EMIT: begin
				ctrl.emit = stat.out_free;
				ctrl.kind = kind_q;
			end
			default: ctrl = '0;
		endcase
	end

endmodule

[rtl/mer_dp.sv]
// Datapath: held command, shared multiplier, walk registers and output word register.
`timescale 1ns / 1ps

module mer_dp import mer_pkg::*; #(
	parameter int RADIUS_BITS = 10,
	parameter int COORD_BITS  = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mer_ctrl_t                    ctrl,
	output mer_stat_t                    stat,
	input  logic signed [COORD_BITS-1:0] center_x,
	input  logic signed [COORD_BITS-1:0] center_y,
	input  logic [RADIUS_BITS-1:0]       radius_x,
	input  logic [RADIUS_BITS-1:0]       radius_y,
	input  logic [QUADS-1:0]             quadrants,
	input  logic                         fill_mode,
	input  logic [COLOR_BITS-1:0]        line_color,
	input  logic [COLOR_BITS-1:0]        fill_color,
	input  logic                         res_ready,
	output logic                         res_valid,
	output logic signed [COORD_BITS:0]   pixel_x,
	output logic signed [COORD_BITS:0]   pixel_y,
	output logic [RADIUS_BITS:0]         span_length,
	output logic [COLOR_BITS-1:0]        out_color,
	output logic                         has_pixel,
	output logic                         is_last,
	output logic                         done_res
);

	localparam int R  = RADIUS_BITS;
	localparam int C  = COORD_BITS;
	localparam int A  = 3 * RADIUS_BITS + 4;
	localparam int TW = A + 2;
	localparam int PW = (COORD_BITS > RADIUS_BITS) ? COORD_BITS + 1 : RADIUS_BITS + 2;
	localparam logic [R:0] WONE = (R+1)'(1);

	// held command
	logic signed [C-1:0]    cx_q, cy_q;
	logic [R-1:0]           rx_q, ry_q;
	logic [QUADS-1:0]       quads_q;
	logic [COLOR_BITS-1:0]  line_q, fillc_q;

	// start products
	logic [2*R-1:0]         rxsq_q, rysq_q;
	logic signed [A-1:0]    x1i_q, y2i_q, sx1i_q, sy2i_q;

	// walk state
	mer_phase_t             phase_q;
	logic                   fill_q;
	logic [R:0]             wx_q, wy_q;
	logic signed [A-1:0]    xch_q, ych_q, err_q, sx_q, sy_q;

	// step snapshot
	logic [R:0]             swx_q, swy_q;
	logic                   sfill_q;
	logic [QUADS-1:0]       pend_q;

	// output word
	logic                   res_valid_q;
	logic signed [C:0]      pixel_x_q, pixel_y_q;
	logic [R:0]             span_q;
	logic [COLOR_BITS-1:0]  color_q;
	logic                   has_q, last_q, done_q;

	// multiplier
	logic signed [2*R+1:0]  mul_a;
	logic signed [R+1:0]    mul_b;
	logic signed [A-1:0]    prod;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctrl.mul_sel)
			MS_RXSQ: begin
				mul_a = (2*R+2)'(rx_q);
				mul_b = (R+2)'(rx_q);
			end
			MS_RYSQ: begin
				mul_a = (2*R+2)'(ry_q);
				mul_b = (R+2)'(ry_q);
			end
			MS_X1: begin
				mul_a = (2*R+2)'(rysq_q);
				mul_b = (R+2)'(1) - {1'b0, rx_q, 1'b0};
			end
			MS_Y2: begin
				mul_a = (2*R+2)'(rxsq_q);
				mul_b = (R+2)'(1) - {1'b0, ry_q, 1'b0};
			end
			MS_SX1: begin
				mul_a = {1'b0, rysq_q, 1'b0};
				mul_b = (R+2)'(rx_q);
			end
			MS_SY2: begin
				mul_a = {1'b0, rxsq_q, 1'b0};
				mul_b = (R+2)'(ry_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// walk arithmetic
	logic signed [A-1:0]  tworx, twory, rxsq_w, rysq_w;
	logic signed [TW-1:0] t_one, t_two;
	logic                 step_x1, step_y2, point, end_one, end_two;
	logic                 r1_go, r2_go, to_idle;

	assign rxsq_w = signed'((A)'(rxsq_q));
	assign rysq_w = signed'((A)'(rysq_q));
	assign tworx  = signed'((A)'({rxsq_q, 1'b0}));
	assign twory  = signed'((A)'({rysq_q, 1'b0}));

	assign t_one   = {err_q[A-1], err_q, 1'b0} + {{2{xch_q[A-1]}}, xch_q};
	assign t_two   = {err_q[A-1], err_q, 1'b0} + {{2{ych_q[A-1]}}, ych_q};
	assign step_x1 = !t_one[TW-1] && (t_one != '0);
	assign step_y2 = !t_two[TW-1] && (t_two != '0);

	assign point   = (rx_q == '0) && (ry_q == '0);
	assign end_one = (phase_q == PH_ONE) && ((sx_q < sy_q) || point);
	assign end_two = (phase_q == PH_TWO) && ((sx_q > sy_q) || point);
	assign r2_go   = ctrl.adv3 && end_one;
	assign r1_go   = ctrl.r1_init || (ctrl.adv3 && end_two && fill_q);
	assign to_idle = ctrl.adv3 && end_two && !fill_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cx_q    <= center_x;
			cy_q    <= center_y;
			rx_q    <= radius_x;
			ry_q    <= radius_y;
			quads_q <= quadrants;
			line_q  <= line_color;
			fillc_q <= fill_color;
		end

		if (ctrl.mul_en) begin
			case (ctrl.mul_sel)
				MS_RXSQ: rxsq_q <= prod[2*R-1:0];
				MS_RYSQ: rysq_q <= prod[2*R-1:0];
				MS_X1:   x1i_q  <= prod;
				MS_Y2:   y2i_q  <= prod;
				MS_SX1:  sx1i_q <= prod;
				MS_SY2:  sy2i_q <= prod;
				default: rxsq_q <= rxsq_q;
			endcase
		end

		if (r1_go) begin
			wx_q  <= {1'b0, rx_q};
			wy_q  <= '0;
			xch_q <= x1i_q;
			ych_q <= rxsq_w;
			err_q <= '0;
			sx_q  <= sx1i_q;
			sy_q  <= '0;
		end else if (r2_go) begin
			wx_q  <= '0;
			wy_q  <= {1'b0, ry_q};
			xch_q <= rysq_w;
			ych_q <= y2i_q;
			err_q <= '0;
			sx_q  <= '0;
			sy_q  <= sy2i_q;
		end else if (ctrl.adv1) begin
			if (phase_q == PH_ONE) begin
				wy_q  <= wy_q + WONE;
				sy_q  <= sy_q + tworx;
				err_q <= err_q + ych_q;
				ych_q <= ych_q + tworx;
			end else begin
				wx_q  <= wx_q + WONE;
				sx_q  <= sx_q + twory;
				err_q <= err_q + xch_q;
				xch_q <= xch_q + twory;
			end
		end else if (ctrl.adv2) begin
			if (phase_q == PH_ONE) begin
				if (step_x1) begin
					wx_q  <= wx_q - WONE;
					sx_q  <= sx_q - twory;
					err_q <= err_q + xch_q;
					xch_q <= xch_q + twory;
				end
			end else if (step_y2) begin
				wy_q  <= wy_q - WONE;
				sy_q  <= sy_q - tworx;
				err_q <= err_q + ych_q;
				ych_q <= ych_q + tworx;
			end
		end

		if (ctrl.snap) begin
			swx_q   <= wx_q;
			swy_q   <= wy_q;
			sfill_q <= fill_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			fill_q  <= 1'b0;
		end else if (ctrl.load) begin
			phase_q <= PH_ONE;
			fill_q  <= fill_mode;
		end else if (r2_go) begin
			phase_q <= PH_TWO;
		end else if (ctrl.adv3 && end_two) begin
			// fill pass done: drop into the outline pass, else finish
			phase_q <= to_idle ? PH_IDLE : PH_ONE;
			fill_q  <= 1'b0;
		end
	end

	// quadrant pick: lowest pending bit first
	logic [1:0]       k;
	logic [QUADS-1:0] rest;
	logic             any;

	always_comb begin
		k = 2'd3;
		if (pend_q[2]) k = 2'd2;
		if (pend_q[1]) k = 2'd1;
		if (pend_q[0]) k = 2'd0;
	end

	assign any  = |pend_q;
	assign rest = pend_q & ~(QUADS'(1) << k);

	logic signed [PW-1:0] cx_w, cy_w, wx_w, wy_w, px_w, py_w;

	assign cx_w = PW'(cx_q);
	assign cy_w = PW'(cy_q);
	assign wx_w = signed'(PW'(swx_q));
	assign wy_w = signed'(PW'(swy_q));
	assign px_w = k[0] ? (cx_w - wx_w) : (cx_w + wx_w);

	always_comb begin
		if (k[1]) begin
			py_w = sfill_q ? cy_w : (cy_w + wy_w);
		end else begin
			py_w = cy_w - wy_w;
		end
	end

	logic signed [C:0]     e_px, e_py;
	logic [R:0]            e_len;
	logic [COLOR_BITS-1:0] e_col;
	logic                  e_has, e_last, e_done;

	always_comb begin
		e_px   = '0;
		e_py   = '0;
		e_len  = '0;
		e_col  = '0;
		e_has  = 1'b0;
		e_last = 1'b1;
		e_done = 1'b0;
		case (ctrl.kind)
			EK_START: e_done = 1'b0;
			EK_IDLE:  e_done = 1'b1;
			EK_POINT: begin
				e_done = (phase_q == PH_IDLE);
				if (any) begin
					e_px   = px_w[C:0];
					e_py   = py_w[C:0];
					e_len  = sfill_q ? (swy_q + WONE) : WONE;
					e_col  = sfill_q ? fillc_q : line_q;
					e_has  = 1'b1;
					e_last = (rest == '0);
				end
			end
			default: e_done = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			pend_q      <= '0;
		end else begin
			if (ctrl.snap) begin
				pend_q <= quads_q;
			end else if (ctrl.emit) begin
				pend_q <= rest;
			end
			if (ctrl.emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			pixel_x_q <= e_px;
			pixel_y_q <= e_py;
			span_q    <= e_len;
			color_q   <= e_col;
			has_q     <= e_has;
			last_q    <= e_last;
			done_q    <= e_done;
		end
	end

	assign stat.idle     = (phase_q == PH_IDLE);
	assign stat.last     = (rest == '0);
	assign stat.out_free = !res_valid_q || res_ready;

	assign res_valid   = res_valid_q;
	assign pixel_x     = pixel_x_q;
	assign pixel_y     = pixel_y_q;
	assign span_length = span_q;
	assign out_color   = color_q;
	assign has_pixel   = has_q;
	assign is_last     = last_q;
	assign done_res    = done_q;

endmodule

[rtl/midpoint_ellipse_rasterizer_top.sv]
// Top level of the midpoint ellipse rasterizer.
// Start word: six products on one shared multiplier, then one result word;
//   the next request is taken once that word is in the output register.
// Step word: three advance steps, then one word per enabled quadrant (one blank word if none),
//   one a cycle while the output register is free; a step in the idle phase gives one done word.
// Reset clears the walk phase to idle and empties the output register.
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer_top import mer_pkg::*; #(
	parameter int RADIUS_BITS = 10,
	parameter int COORD_BITS  = 12
) (
	input logic       clk,
	input logic       arst_n,
	mer_req_if.sink   req,
	mer_res_if.source res
);

	mer_ctrl_t ctrl;
	mer_stat_t stat;

	mer_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (req.ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	mer_dp #(
		.RADIUS_BITS (RADIUS_BITS),
		.COORD_BITS  (COORD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.stat        (stat),
		.center_x    (req.center_x),
		.center_y    (req.center_y),
		.radius_x    (req.radius_x),
		.radius_y    (req.radius_y),
		.quadrants   (req.quadrants),
		.fill_mode   (req.fill_mode),
		.line_color  (req.line_color),
		.fill_color  (req.fill_color),
		.res_ready   (res.ready),
		.res_valid   (res.valid),
		.pixel_x     (res.pixel_x),
		.pixel_y     (res.pixel_y),
		.span_length (res.span_length),
		.out_color   (res.out_color),
		.has_pixel   (res.has_pixel),
		.is_last     (res.is_last),
		.done_res    (res.done_res)
	);

endmodule

[rtl/mer_checker.sv]
// Port-level assertions for the rasterizer and their bind to the top level.
`timescale 1ns / 1ps

module mer_checker import mer_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_valid,
	input logic                  req_ready,
	input logic                  res_valid,
	input logic                  res_ready,
	input logic                  has_pixel,
	input logic                  is_last,
	input logic                  done_res,
	input logic [COLOR_BITS-1:0] out_color
);

	// a request word always starts work, so the block is busy on the next cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous word still in work");

	// quadrant words of one step follow each other without a gap
	a_burst_dense: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !is_last |=> res_valid)
		else $error("gap inside a multi-word step");

	// a word without a pixel is always the only word of its request
	a_blank_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !has_pixel |-> is_last)
		else $error("blank result word not marked last");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(has_pixel) && $stable(is_last)
			&& $stable(done_res) && $stable(out_color))
		else $error("stalled result word changed");

endmodule

bind midpoint_ellipse_rasterizer_top mer_checker u_mer_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.has_pixel (res.has_pixel),
	.is_last   (res.is_last),
	.done_res  (res.done_res),
	.out_color (res.out_color)
);

[tb/tb_midpoint_ellipse_rasterizer_top.sv]
// Self-checking testbench for the midpoint ellipse rasterizer top level.
`timescale 1ns / 1ps

module tb_midpoint_ellipse_rasterizer_top import mer_pkg::*;;

	localparam int RB = 10;
	localparam int CB = 12;

	typedef struct packed {
		logic                  kind;
		logic signed [CB-1:0]  cx;
		logic signed [CB-1:0]  cy;
		logic [RB-1:0]         rx;
		logic [RB-1:0]         ry;
		logic [QUADS-1:0]      quads;
		logic                  fill;
		logic [COLOR_BITS-1:0] lcol;
		logic [COLOR_BITS-1:0] fcol;
	} ellipse_req_t;

	typedef struct packed {
		logic signed [CB:0]    px;
		logic signed [CB:0]    py;
		logic [RB:0]           len;
		logic [COLOR_BITS-1:0] col;
		logic                  has;
		logic                  last;
		logic                  done;
	} pixel_word_t;

	logic clk = 1'b0;
	logic arst_n;

	mer_req_if #(.RADIUS_BITS(RB), .COORD_BITS(CB)) req_ch ();
	mer_res_if #(.RADIUS_BITS(RB), .COORD_BITS(CB)) res_ch ();

	midpoint_ellipse_rasterizer_top #(.RADIUS_BITS(RB), .COORD_BITS(CB)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Walk state of the expected drawing
	mer_phase_t   walk_phase = PH_IDLE;
	bit           fill_pass  = 1'b0;
	logic [RB:0]  walk_x     = '0;
	logic [RB:0]  walk_y     = '0;
	longint       x_chg = 0, y_chg = 0, err_acc = 0, stop_x = 0, stop_y = 0;
	longint       two_rx_sq = 0, two_ry_sq = 0;
	ellipse_req_t held = '0;

	pixel_word_t  pending_words[$];
	int           error_count = 0;
	int           items_sent  = 0;
	bit           jitter_on   = 1'b1;

	task automatic report_error(string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		error_count++;
	endtask

	function automatic void load_region_one();
		longint rx, ry;
		rx = longint'(held.rx);
		ry = longint'(held.ry);
		walk_x  = {1'b0, held.rx};
		walk_y  = '0;
		x_chg   = (1 - 2 * rx) * ry * ry;
		y_chg   = rx * rx;
		err_acc = 0;
		stop_x  = two_ry_sq * rx;
		stop_y  = 0;
	endfunction

	// Work out the words one request produces and update the walk
	function automatic void predict_words(ellipse_req_t r);
		pixel_word_t words[$];
		pixel_word_t w;
		longint      rx, ry, cx, cy, px, py;
		bit          dot;
		if (r.kind == REQ_START) begin
			held      = r;
			rx        = longint'(r.rx);
			ry        = longint'(r.ry);
			two_rx_sq = 2 * rx * rx;
			two_ry_sq = 2 * ry * ry;
			fill_pass = r.fill;
			walk_phase = PH_ONE;
			load_region_one();
			w = '0;
			w.last = 1'b1;
			pending_words.push_back(w);
			return;
		end
		if (walk_phase == PH_IDLE) begin
			w = '0;
			w.last = 1'b1;
			w.done = 1'b1;
			pending_words.push_back(w);
			return;
		end
		rx = longint'(held.rx);
		ry = longint'(held.ry);
		cx = longint'(held.cx);
		cy = longint'(held.cy);
		for (int k = 0; k < QUADS; k++) begin
			if (!held.quads[k])
				continue;
			w = '0;
			px = k[0] ? cx - longint'(walk_x) : cx + longint'(walk_x);
			if (fill_pass) begin
				py    = k[1] ? cy : cy - longint'(walk_y);
				w.len = walk_y + 1'b1;
				w.col = held.fcol;
			end else begin
				py    = k[1] ? cy + longint'(walk_y) : cy - longint'(walk_y);
				w.len = (RB+1)'(1);
				w.col = held.lcol;
			end
			w.px  = px[CB:0];
			w.py  = py[CB:0];
			w.has = 1'b1;
			words.push_back(w);
		end
		if (words.size() == 0)
			words.push_back('0);

		// Both radii zero: one point per region, then move on
		dot = (rx == 0 && ry == 0);
		if (walk_phase == PH_ONE) begin
			walk_y  = walk_y + 1'b1;
			stop_y += two_rx_sq;
			err_acc += y_chg;
			y_chg  += two_rx_sq;
			if (2 * err_acc + x_chg > 0) begin
				walk_x  = walk_x - 1'b1;
				stop_x -= two_ry_sq;
				err_acc += x_chg;
				x_chg  += two_ry_sq;
			end
			if (stop_x < stop_y || dot) begin
				walk_phase = PH_TWO;
				walk_x  = '0;
				walk_y  = {1'b0, held.ry};
				x_chg   = ry * ry;
				y_chg   = (1 - 2 * ry) * rx * rx;
				err_acc = 0;
				stop_x  = 0;
				stop_y  = two_rx_sq * ry;
			end
		end else begin
			walk_x  = walk_x + 1'b1;
			stop_x += two_ry_sq;
			err_acc += x_chg;
			x_chg  += two_ry_sq;
			if (2 * err_acc + y_chg > 0) begin
				walk_y  = walk_y - 1'b1;
				stop_y -= two_rx_sq;
				err_acc += y_chg;
				y_chg  += two_rx_sq;
			end
			if (stop_x > stop_y || dot) begin
				if (fill_pass) begin
					fill_pass  = 1'b0;
					walk_phase = PH_ONE;
					load_region_one();
				end else begin
					walk_phase = PH_IDLE;
				end
			end
		end
		foreach (words[i]) begin
			words[i].done = (walk_phase == PH_IDLE);
			words[i].last = (i == words.size() - 1);
			pending_words.push_back(words[i]);
		end
	endfunction

	function automatic ellipse_req_t make_start(logic signed [CB-1:0] cx,
			logic signed [CB-1:0] cy, logic [RB-1:0] rx, logic [RB-1:0] ry,
			logic [QUADS-1:0] quads, logic fill, logic [COLOR_BITS-1:0] lcol,
			logic [COLOR_BITS-1:0] fcol);
		ellipse_req_t r;
		r.kind  = REQ_START;
		r.cx    = cx;
		r.cy    = cy;
		r.rx    = rx;
		r.ry    = ry;
		r.quads = quads;
		r.fill  = fill;
		r.lcol  = lcol;
		r.fcol  = fcol;
		return r;
	endfunction

	// Step words carry random content in the fields they ignore
	function automatic ellipse_req_t make_step();
		ellipse_req_t r;
		r = make_start(CB'($urandom), CB'($urandom), RB'($urandom), RB'($urandom),
			QUADS'($urandom), 1'($urandom), COLOR_BITS'($urandom),
			COLOR_BITS'($urandom));
		r.kind = REQ_STEP;
		return r;
	endfunction

	task automatic send_word(ellipse_req_t r);
		if (jitter_on && $urandom_range(0, 99) < 33) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= r.kind;
		req_ch.center_x   <= r.cx;
		req_ch.center_y   <= r.cy;
		req_ch.radius_x   <= r.rx;
		req_ch.radius_y   <= r.ry;
		req_ch.quadrants  <= r.quads;
		req_ch.fill_mode  <= r.fill;
		req_ch.line_color <= r.lcol;
		req_ch.fill_color <= r.fcol;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		predict_words(r);
		items_sent++;
	endtask

	// Step until the drawing ends or the budget runs out
	task automatic draw_steps(int budget);
		for (int i = 0; i < budget && walk_phase != PH_IDLE; i++)
			send_word(make_step());
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_idle_steps();
		send_word(make_step());
		send_word(make_step());
	endtask

	task automatic test_degenerate_radii();
		send_word(make_start(12'sh800, 12'sh7ff, 10'd0, 10'd0, 4'hf, 1'b1,
			24'hffffff, 24'h000000));
		draw_steps(8);
		send_word(make_start(12'sh7ff, 12'sh800, 10'd1023, 10'd0, 4'hf, 1'b0,
			24'h000000, 24'hffffff));
		draw_steps(8);
		send_word(make_start(12'sh000, 12'sh000, 10'd0, 10'd1023, 4'h9, 1'b0,
			24'h5a5a5a, 24'ha5a5a5));
		draw_steps(8);
		// Largest ellipse: a few steps, then abandon it
		send_word(make_start(12'sh800, 12'sh800, 10'd1023, 10'd1023, 4'hf, 1'b1,
			24'hffffff, 24'hffffff));
		draw_steps(2);
	endtask

	task automatic test_quadrant_masks();
		logic [QUADS-1:0] masks[5] = '{4'h0, 4'h1, 4'h2, 4'h4, 4'h8};
		foreach (masks[i]) begin
			send_word(make_start(CB'($urandom), CB'($urandom), 10'd2, 10'd1, masks[i],
				i[0], COLOR_BITS'($urandom), COLOR_BITS'($urandom)));
			draw_steps(1);
		end
	endtask

	task automatic test_steady_flow();
		jitter_on = 1'b0;
		send_word(make_start(CB'($urandom), CB'($urandom), 10'd9, 10'd6, 4'hf, 1'b1,
			COLOR_BITS'($urandom), COLOR_BITS'($urandom)));
		draw_steps(200);
		jitter_on = 1'b1;
	endtask

	task automatic test_drain_pause();
		send_word(make_start(CB'($urandom), CB'($urandom), 10'd4, 10'd7, 4'hf, 1'b0,
			COLOR_BITS'($urandom), COLOR_BITS'($urandom)));
		draw_steps(3);
		wait_drained();
		draw_steps(200);
	endtask

	task automatic test_random_ellipses(int target);
		int sel, budget;
		logic [RB-1:0] rx, ry;
		while (items_sent < target) begin
			if ($urandom_range(0, 99) < 8)
				send_word(make_step());
			sel = $urandom_range(0, 99);
			budget = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 10) : 300;
			if (sel < 75) begin
				rx = RB'($urandom_range(0, 12));
				ry = RB'($urandom_range(0, 12));
			end else if (sel < 83) begin
				rx = RB'($urandom_range(0, 40));
				ry = RB'($urandom_range(0, 40));
			end else begin
				rx = RB'($urandom);
				ry = RB'($urandom);
				budget = $urandom_range(1, 6);
			end
			send_word(make_start(CB'($urandom), CB'($urandom), rx, ry,
				($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'hf,
				1'($urandom), COLOR_BITS'($urandom), COLOR_BITS'($urandom)));
			// keep the total near the target
			if (budget > target - items_sent)
				budget = target - items_sent;
			draw_steps(budget);
			if (walk_phase == PH_IDLE && $urandom_range(0, 99) < 20)
				send_word(make_step());
		end
	endtask

	always @(posedge clk) begin
		res_ch.ready <= (arst_n !== 1'b1) ? 1'b0 :
			(!jitter_on || $urandom_range(0, 99) >= 33);
	end

	// Check every word the block hands over against the oldest expectation
	always @(posedge clk) begin
		pixel_word_t want;
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (pending_words.size() == 0) begin
				report_error("result word with nothing expected");
			end else begin
				want = pending_words.pop_front();
				if (res_ch.pixel_x !== want.px)
					report_error($sformatf("pixel_x %0d, want %0d", res_ch.pixel_x, want.px));
				if (res_ch.pixel_y !== want.py)
					report_error($sformatf("pixel_y %0d, want %0d", res_ch.pixel_y, want.py));
				if (res_ch.span_length !== want.len)
					report_error($sformatf("span_length %0d, want %0d",
						res_ch.span_length, want.len));
				if (res_ch.out_color !== want.col)
					report_error($sformatf("out_color %h, want %h", res_ch.out_color, want.col));
				if (res_ch.has_pixel !== want.has)
					report_error($sformatf("has_pixel %b, want %b", res_ch.has_pixel, want.has));
				if (res_ch.is_last !== want.last)
					report_error($sformatf("is_last %b, want %b", res_ch.is_last, want.last));
				if (res_ch.done_res !== want.done)
					report_error($sformatf("done_res %b, want %b", res_ch.done_res, want.done));
			end
		end
	end

	initial begin
		arst_n            <= 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.req_type   <= REQ_START;
		req_ch.center_x   <= '0;
		req_ch.center_y   <= '0;
		req_ch.radius_x   <= '0;
		req_ch.radius_y   <= '0;
		req_ch.quadrants  <= '0;
		req_ch.fill_mode  <= 1'b0;
		req_ch.line_color <= '0;
		req_ch.fill_color <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_steps();
		test_degenerate_radii();
		test_quadrant_masks();
		test_steady_flow();
		test_drain_pause();
		test_random_ellipses(470);

		wait_drained();
		repeat (30) @(posedge clk);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#5ms;
		$display("FAILURE");
		$finish;
	end

endmodule

[midpoint_ellipse_rasterizer_top.f]
rtl/mer_pkg.sv
rtl/mer_req_if.sv
rtl/mer_res_if.sv
rtl/mer_ctrl.sv
rtl/mer_dp.sv
rtl/midpoint_ellipse_rasterizer_top.sv
rtl/mer_checker.sv
tb/tb_midpoint_ellipse_rasterizer_top.sv
